/* rtl/signed_radix_to_seven_segment_macros.svh */
`ifndef SIGNED_RADIX_TO_SEVEN_SEGMENT_MACROS_SVH
`define SIGNED_RADIX_TO_SEVEN_SEGMENT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SRSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srss_pkg.sv */
`default_nettype none

package srss_pkg;

    localparam int MAG_W     = 16;
    localparam int NUM_STEPS = 12;
    localparam int STEP_W    = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [7:0] MINUS_RESET = 8'd64;
    localparam logic [7:0] BLANK_RESET = 8'd0;
    localparam logic [7:0] ZERO_RESET  = 8'd63;

    typedef enum logic [1:0] {
        REG_MINUS = 2'd0,
        REG_BLANK = 2'd1,
        REG_ZERO  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] number;
        logic [4:0]         radix;
    } in_t;

    typedef struct packed {
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_last;
        logic       overflow;
    } out_t;

    typedef struct packed {
        logic [7:0] minus;
        logic [7:0] blank;
        logic [7:0] zero;
    } codes_t;

    // Data handed from cell to cell along the digit chain
    typedef struct packed {
        logic             zero;
        logic             ovf;
        logic             neg;
        logic [MAG_W-1:0] rem;
        logic [11:0]      digits;
        logic [4:0]       p1;
        logic [8:0]       p2;
        logic [12:0]      p3;
    } work_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  p1;
        logic [8:0]  p2;
        logic [12:0] p3;
        logic [16:0] p4;
    } pow_t;

    function automatic pow_t pow_lookup(input logic [4:0] radix);
        pow_t p;
        p = '0;
        p.ok = 1'b1;
        p.p1 = radix;
        unique case (radix)
            5'd2:    begin p.p2 = 9'd4;   p.p3 = 13'd8;    p.p4 = 17'd16;    end
            5'd3:    begin p.p2 = 9'd9;   p.p3 = 13'd27;   p.p4 = 17'd81;    end
            5'd4:    begin p.p2 = 9'd16;  p.p3 = 13'd64;   p.p4 = 17'd256;   end
            5'd5:    begin p.p2 = 9'd25;  p.p3 = 13'd125;  p.p4 = 17'd625;   end
            5'd6:    begin p.p2 = 9'd36;  p.p3 = 13'd216;  p.p4 = 17'd1296;  end
            5'd7:    begin p.p2 = 9'd49;  p.p3 = 13'd343;  p.p4 = 17'd2401;  end
            5'd8:    begin p.p2 = 9'd64;  p.p3 = 13'd512;  p.p4 = 17'd4096;  end
            5'd9:    begin p.p2 = 9'd81;  p.p3 = 13'd729;  p.p4 = 17'd6561;  end
            5'd10:   begin p.p2 = 9'd100; p.p3 = 13'd1000; p.p4 = 17'd10000; end
            5'd11:   begin p.p2 = 9'd121; p.p3 = 13'd1331; p.p4 = 17'd14641; end
            5'd12:   begin p.p2 = 9'd144; p.p3 = 13'd1728; p.p4 = 17'd20736; end
            5'd13:   begin p.p2 = 9'd169; p.p3 = 13'd2197; p.p4 = 17'd28561; end
            5'd14:   begin p.p2 = 9'd196; p.p3 = 13'd2744; p.p4 = 17'd38416; end
            5'd15:   begin p.p2 = 9'd225; p.p3 = 13'd3375; p.p4 = 17'd50625; end
            5'd16:   begin p.p2 = 9'd256; p.p3 = 13'd4096; p.p4 = 17'd65536; end
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_seg(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/srss_prep.sv */
`default_nettype none

module srss_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire srss_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output srss_pkg::work_t      out_work
);
    import srss_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    work_t              work_reg;
    work_t              work_next;
    pow_t               pw;
    logic signed [31:0] neg_p3;
    logic               big;

    always_comb
    begin
        pw     = pow_lookup(in_data.radix);
        neg_p3 = -$signed({19'b0, pw.p3});
        if (in_data.number[31])
        begin
            big = (in_data.number <= neg_p3);
        end
        else
        begin
            big = (in_data.number >= $signed({15'b0, pw.p4}));
        end

        work_next        = '0;
        work_next.zero   = (in_data.number == 32'sd0);
        work_next.ovf    = !pw.ok || big;
        work_next.neg    = in_data.number[31];
        // low half is the whole magnitude whenever the value is in range
        work_next.rem    = in_data.number[31] ? (16'd0 - in_data.number[15:0])
                                              : in_data.number[15:0];
        work_next.digits = '0;
        work_next.p1     = pw.p1;
        work_next.p2     = pw.p2;
        work_next.p3     = pw.p3;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

/* rtl/srss_cell.sv */
`default_nettype none

// One restoring-division step: digit step[3:2], quotient bit 3 - step[1:0].
module srss_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [srss_pkg::STEP_W-1:0]   step,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire srss_pkg::work_t               in_work,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output srss_pkg::work_t                    out_work
);
    import srss_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    work_t            work_reg;
    work_t            work_next;
    logic [12:0]      pow;
    logic [1:0]       sh;
    logic [MAG_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        unique case (step[3:2])
            2'd0:    pow = in_work.p3;
            2'd1:    pow = {4'b0, in_work.p2};
            2'd2:    pow = {8'b0, in_work.p1};
            default: pow = '0;
        endcase
        sh    = ~step[1:0];
        trial = {3'b0, pow} << sh;
        ge    = (in_work.rem >= trial);

        work_next        = in_work;
        work_next.rem    = ge ? (in_work.rem - trial) : in_work.rem;
        work_next.digits = {in_work.digits[10:0], ge};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

/* rtl/srss_fmt.sv */
`default_nettype none

module srss_fmt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srss_pkg::codes_t   codes,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire srss_pkg::work_t    in_work,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output srss_pkg::out_t          out_data
);
    import srss_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    out_t       data_reg;
    out_t       data_next;
    logic [3:0] d0, d1, d2, d3;
    logic       nz0, nz1, nz2, nz3;
    logic       s1, s2, s3;

    always_comb
    begin
        d0  = in_work.digits[11:8];
        d1  = in_work.digits[7:4];
        d2  = in_work.digits[3:0];
        d3  = in_work.rem[3:0];
        nz0 = (d0 != 4'd0);
        nz1 = (d1 != 4'd0);
        nz2 = (d2 != 4'd0);
        nz3 = (d3 != 4'd0);
        // sN: a nonzero digit stands left of position N
        s1  = nz0;
        s2  = s1 || nz1;
        s3  = s2 || nz2;

        data_next            = '0;
        data_next.seg_first  = nz0 ? hex_seg(d0) : codes.blank;
        data_next.seg_second = (s1 || nz1) ? hex_seg(d1) : codes.blank;
        data_next.seg_third  = (s2 || nz2) ? hex_seg(d2) : codes.blank;
        data_next.seg_last   = (s3 || nz3) ? hex_seg(d3) : codes.blank;
        if (in_work.neg)
        begin
            if (!s1 && nz1)
            begin
                data_next.seg_first = codes.minus;
            end
            if (!s2 && nz2)
            begin
                data_next.seg_second = codes.minus;
            end
            if (!s3 && nz3)
            begin
                data_next.seg_third = codes.minus;
            end
        end

        priority if (in_work.zero)
        begin
            data_next          = '0;
            data_next.seg_last = codes.zero;
        end
        else if (in_work.ovf)
        begin
            data_next          = '0;
            data_next.overflow = 1'b1;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/signed_radix_to_seven_segment.sv */
// Pipeline: range check stage, twelve division-step cells, format/output stage.
// Throughput: one item per cycle while the output is not stalled; every stage has
// its own valid, so bubbles close up while the output is stalled.
// Reset: rst_n asynchronous, active low; empties the pipeline and loads the
// minus, blank and zero codes with 64, 0 and 63.
`default_nettype none

`include "signed_radix_to_seven_segment_macros.svh"

module signed_radix_to_seven_segment (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srss_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [srss_pkg::DATA_W-1:0]   pwdata,
    output logic [srss_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire srss_pkg::in_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output srss_pkg::out_t                     out_data
);
    import srss_pkg::*;

    codes_t                codes_reg;
    codes_t                codes_next;
    logic                  wr_en;

    work_t                 chain_work  [0:NUM_STEPS];
    logic [NUM_STEPS:0]    chain_valid;
    logic [NUM_STEPS:0]    chain_ready;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        codes_next = codes_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_MINUS: codes_next.minus = pwdata[7:0];
                REG_BLANK: codes_next.blank = pwdata[7:0];
                REG_ZERO:  codes_next.zero  = pwdata[7:0];
                default:   codes_next = codes_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MINUS: prdata = {24'b0, codes_reg.minus};
            REG_BLANK: prdata = {24'b0, codes_reg.blank};
            REG_ZERO:  prdata = {24'b0, codes_reg.zero};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.minus <= MINUS_RESET;
            codes_reg.blank <= BLANK_RESET;
            codes_reg.zero  <= ZERO_RESET;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    // Datapath
    srss_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_work  (chain_work[0])
    );

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        srss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    srss_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .codes     (codes_reg),
        .in_valid  (chain_valid[NUM_STEPS]),
        .in_ready  (chain_ready[NUM_STEPS]),
        .in_work   (chain_work[NUM_STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Checks
    `SRSS_ASSERT_NOW(a_ovf_blank, out_valid && out_data.overflow,
        (out_data.seg_first == 8'd0) && (out_data.seg_second == 8'd0) &&
        (out_data.seg_third == 8'd0) && (out_data.seg_last == 8'd0),
        "overflow result with nonzero segments")
    `SRSS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
        "input stalled while output side is free")
    `SRSS_ASSERT_NEXT(a_minus_write, wr_en && (paddr[3:2] == REG_MINUS),
        codes_reg.minus == $past(pwdata[7:0]),
        "minus code write lost")

endmodule

`default_nettype wire

/* tb/signed_radix_to_seven_segment_test.sv */
`timescale 1ns / 1ps

module signed_radix_to_seven_segment_test;

    import srss_pkg::*;

    localparam int          PIPE_DEPTH     = 14;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;

    // segment bytes for digits 0..F, bit0 = A .. bit6 = G; entry [d] is digit d
    localparam logic [15:0][7:0] DIGIT_SEGMENTS = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct {
        in_t  sent;
        out_t shown;
    } display_check_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_t                 in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_t                out_data;

    logic [7:0]          minus_pattern = MINUS_RESET;
    logic [7:0]          blank_pattern = BLANK_RESET;
    logic [7:0]          zero_pattern  = ZERO_RESET;

    display_check_t      pending_displays[$];
    int unsigned         fail_count   = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         ready_hold   = 0;
    bit                  gaps_on      = 1'b1;
    bit                  stalls_on    = 1'b1;

    signed_radix_to_seven_segment dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic out_t format_display(input in_t item);
        out_t            res;
        longint          value;
        longint          base;
        longint          cube;
        longint          fourth;
        longint          mag;
        logic [3:0]      digits [4];
        logic [7:0]      segs [4];
        bit              lead;
        res   = '0;
        value = item.number;
        base  = item.radix;
        if (value == 0)
        begin
            res.seg_last = zero_pattern;
            return res;
        end
        if (base < 2 || base > 16)
        begin
            res.overflow = 1'b1;
            return res;
        end
        cube   = base * base * base;
        fourth = cube * base;
        if (value <= -cube || value >= fourth)
        begin
            res.overflow = 1'b1;
            return res;
        end
        mag = (value < 0) ? -value : value;
        for (int i = 3; i >= 0; i--)
        begin
            digits[i] = 4'(mag % base);
            mag       = mag / base;
        end
        lead = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (lead || digits[i] != 0)
            begin
                segs[i] = DIGIT_SEGMENTS[digits[i]];
                // minus sits right before the first significant digit
                if (!lead && value < 0 && i > 0)
                    segs[i-1] = minus_pattern;
                lead = 1'b1;
            end
            else
                segs[i] = blank_pattern;
        end
        res.seg_first  = segs[0];
        res.seg_second = segs[1];
        res.seg_third  = segs[2];
        res.seg_last   = segs[3];
        return res;
    endfunction

    function automatic int unsigned random_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] code_of(input logic [1:0] index);
        case (index)
            REG_MINUS: return minus_pattern;
            REG_BLANK: return blank_pattern;
            default:   return zero_pattern;
        endcase
    endfunction

    function automatic in_t random_number_item();
        in_t         item;
        int unsigned roll;
        int unsigned base;
        int unsigned digit_count;
        longint      cube;
        longint      fourth;
        longint      span;
        longint      mag;
        bit          neg;
        roll   = $urandom_range(0, 99);
        base   = $urandom_range(2, 16);
        cube   = base * base * base;
        fourth = cube * base;
        item.radix  = base[4:0];
        item.number = '0;
        if (roll < 5)
        begin
            item.radix = 5'($urandom_range(0, 31));
        end
        else if (roll < 10)
        begin
            item.number = $urandom;
            if (item.number == 0)
                item.number = 1;
            item.radix = $urandom_range(0, 1) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 1));
        end
        else if (roll < 20)
            item.number = $urandom;
        else if (roll < 30)
        begin
            case ($urandom_range(0, 3))
                0:       mag = -cube;
                1:       mag = 1 - cube;
                2:       mag = fourth - 1;
                default: mag = fourth;
            endcase
            item.number = mag[31:0];
        end
        else
        begin
            // spread over digit counts so leading blanks show up often
            neg         = ($urandom_range(0, 2) == 0);
            digit_count = $urandom_range(1, neg ? 3 : 4);
            span        = 1;
            repeat (digit_count) span = span * base;
            mag = $urandom_range(1, 32'(span - 1));
            if (neg)
                mag = -mag;
            item.number = mag[31:0];
        end
        return item;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_number(input in_t item);
        display_check_t entry;
        int unsigned    gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? random_pause() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            in_data  <= in_t'({$urandom, 5'($urandom)});
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        entry.sent  = item;
        entry.shown = format_display(item);
        pending_displays.push_back(entry);
    endtask

    task automatic send_value(input longint value, input int unsigned base);
        in_t item;
        item.number = value[31:0];
        item.radix  = base[4:0];
        send_number(item);
    endtask

    // stop sending and let every expected display come out
    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 6) @(negedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [1:0] index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        logic [31:0] byte_addr;
        byte_addr = 32'(index) * 4;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= byte_addr[ADDR_W-1:0];
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_code(input logic [1:0] index);
        logic [31:0] readback;
        apb_access(1'b0, index, 32'h0, readback);
        if (readback[7:0] !== code_of(index))
            report_failure($sformatf("register %0d readback: expected %h, got %h",
                                     index, code_of(index), readback[7:0]));
    endtask

    task automatic write_code(input logic [1:0] index, input logic [7:0] code);
        logic [31:0] wdata;
        logic [31:0] unused_rdata;
        // upper bits carry junk; only the low byte is kept
        wdata      = $urandom;
        wdata[7:0] = code;
        apb_access(1'b1, index, wdata, unused_rdata);
        case (index)
            REG_MINUS: minus_pattern = code;
            REG_BLANK: blank_pattern = code;
            REG_ZERO:  zero_pattern  = code;
            default:   ;
        endcase
        if (index != REG_UNUSED)
            check_code(index);
    endtask

    task automatic test_directed_reset_codes();
        check_code(REG_MINUS);
        check_code(REG_BLANK);
        check_code(REG_ZERO);
        send_value(0, 10);
        send_value(0, 0);
        send_value(0, 31);
        send_value(1, 10);
        send_value(-1, 10);
        send_value(100, 10);
        send_value(1234, 10);
        send_value(9999, 10);
        send_value(10000, 10);
        send_value(-999, 10);
        send_value(-1000, 10);
        send_value(65535, 16);
        send_value(65536, 16);
        send_value(-4095, 16);
        send_value(-4096, 16);
        send_value(-16, 16);
        send_value(15, 2);
        send_value(16, 2);
        send_value(-7, 2);
        send_value(-8, 2);
        send_value(2147483647, 10);
        send_value(-2147483648, 10);
        send_value(5, 0);
        send_value(-5, 1);
        send_value(5, 17);
        send_value(-3, 31);
    endtask

    task automatic send_code_probe();
        send_value(0, 10);
        send_value(-5, 10);
        send_value(-170, 16);
        send_value(7, 8);
    endtask

    task automatic test_code_registers();
        settle_pipeline();
        write_code(REG_MINUS, 8'hFF);
        write_code(REG_BLANK, 8'hFF);
        write_code(REG_ZERO,  8'hFF);
        send_code_probe();
        settle_pipeline();
        write_code(REG_MINUS, 8'h00);
        write_code(REG_BLANK, 8'h00);
        write_code(REG_ZERO,  8'h00);
        send_code_probe();
        settle_pipeline();
        // distinct patterns catch swapped register decode
        write_code(REG_MINUS, 8'h80);
        write_code(REG_BLANK, 8'h01);
        write_code(REG_ZERO,  8'h55);
        write_code(REG_UNUSED, pick_code());
        check_code(REG_MINUS);
        check_code(REG_BLANK);
        check_code(REG_ZERO);
        send_code_probe();
        settle_pipeline();
        write_code(REG_MINUS, MINUS_RESET);
        write_code(REG_BLANK, BLANK_RESET);
        write_code(REG_ZERO,  ZERO_RESET);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            settle_pipeline();
            if (phase != 0)
            begin
                write_code(REG_MINUS, pick_code());
                write_code(REG_BLANK, pick_code());
                write_code(REG_ZERO,  pick_code());
            end
            // one phase runs back to back with the sink always ready
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            for (int n = 0; n < 185; n++)
            begin
                if (n == 90)
                    settle_pipeline();
                send_number(random_number_item());
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // sink-side backpressure
    always @(negedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 99) < 25)
        begin
            ready_hold <= random_pause() - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        display_check_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_displays.size() == 0)
                report_failure($sformatf("unexpected transfer: %h %h %h %h ovf %b",
                                         out_data.seg_first, out_data.seg_second,
                                         out_data.seg_third, out_data.seg_last,
                                         out_data.overflow));
            else
            begin
                want = pending_displays.pop_front();
                if (out_data.seg_first  !== want.shown.seg_first  ||
                    out_data.seg_second !== want.shown.seg_second ||
                    out_data.seg_third  !== want.shown.seg_third  ||
                    out_data.seg_last   !== want.shown.seg_last   ||
                    out_data.overflow   !== want.shown.overflow)
                    report_failure($sformatf(
                        "number %0d radix %0d: expected %h %h %h %h ovf %b, got %h %h %h %h ovf %b",
                        want.sent.number, want.sent.radix,
                        want.shown.seg_first, want.shown.seg_second,
                        want.shown.seg_third, want.shown.seg_last, want.shown.overflow,
                        out_data.seg_first, out_data.seg_second,
                        out_data.seg_third, out_data.seg_last, out_data.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("signed_radix_to_seven_segment verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_reset_codes();
        test_code_registers();
        test_random_traffic();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 16) @(posedge clk);
        if (pending_displays.size() != 0)
            report_failure("displays still outstanding at end of run");
        if (fail_count == 0)
            $display("signed_radix_to_seven_segment verification clean");
        else
            $display("signed_radix_to_seven_segment verification failed");
        $finish;
    end

endmodule
